/* hdl/assert_macros.svh */
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define CCT_ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("connected component tracker assertion failed");

// Same, on the conventional clk_i and rst_ni of the enclosing module.
`define CCT_ASSERT(label, prop) `CCT_ASSERT_CLK(label, clk_i, rst_ni, prop)

`endif

/* hdl/cct_pkg.sv */
`timescale 1ns / 1ps

package cct_pkg;

  localparam int unsigned NUM_ELEMENTS = 256;
  localparam int unsigned IDX_W        = $clog2(NUM_ELEMENTS);
  localparam int unsigned SCAN_CNT_W   = $clog2(NUM_ELEMENTS + 1);

  localparam int unsigned ELEM_W       = 8;
  localparam int unsigned COMP_W       = 8;
  localparam int unsigned ID_CNT_W     = 9;
  localparam logic [ID_CNT_W-1:0] ID_CNT_MAX = '1;

  typedef enum logic [1:0] {
    MODE_ADD,
    MODE_CONNECT,
    MODE_QUERY,
    MODE_SAME
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK,
    STATUS_PRESENT,
    STATUS_MISSING
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SCAN,
    ST_RESP
  } state_e;

endpackage

/* hdl/connected_component_tracker.sv */
`timescale 1ns / 1ps

// Quick-find union-find over a table of element slots.
// Input channel: one word per operation (mode_i, elem_a_i, elem_b_i), taken when
// in_valid_i is high and in_stall_o is low. Output channel: one word per operation
// (status_o, comp_id_o, found_o, same_o), taken when out_valid_o is high and
// out_stall_i is low.
// Add, query, same-component and a connect that needs no relabeling raise
// out_valid_o after the table read registered at the accepting edge, evaluation
// in ST_LOOKUP and the load of the output register in ST_RESP.
// A connect that merges two components scans every slot through one of the two
// read ports of the component memory, one slot per cycle, relabeling each slot
// of the merged component before it goes to ST_RESP.
// The block works on one operation at a time; the next word can be taken in the
// cycle after the result is loaded into the output register.
// Reset clears all slot valid bits and the id counter at once; there is no
// clearing pass, so the first word can be taken in the cycle after reset.
// While the receiver stalls, the output word holds; a finished result then waits
// in the block and no new word is taken until the output register is free.
module connected_component_tracker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  mode_i,
  input  logic [cct_pkg::ELEM_W-1:0]  elem_a_i,
  input  logic [cct_pkg::ELEM_W-1:0]  elem_b_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  status_o,
  output logic [cct_pkg::COMP_W-1:0]  comp_id_o,
  output logic                        found_o,
  output logic                        same_o
);

  localparam int unsigned NUM   = cct_pkg::NUM_ELEMENTS;
  localparam int unsigned IDX_W = cct_pkg::IDX_W;
  localparam int unsigned CNT_W = cct_pkg::SCAN_CNT_W;
  localparam int unsigned EW    = cct_pkg::ELEM_W;
  localparam int unsigned CW    = cct_pkg::COMP_W;
  localparam int unsigned IDW   = cct_pkg::ID_CNT_W;

  cct_pkg::state_e  state_q, state_d;
  cct_pkg::mode_e   mode_q, mode_d;
  logic [EW-1:0]    a_q, a_d, b_q, b_d;
  logic [IDW-1:0]   next_id_q, next_id_d;
  logic [NUM-1:0]   valid_q, valid_d;
  logic [CW-1:0]    keep_q, keep_d, gone_q, gone_d;
  logic [CNT_W-1:0] scan_q, scan_d;
  logic [IDX_W-1:0] scan_addr_q, scan_addr_d;
  logic             pend_q, pend_d;

  cct_pkg::status_e res_status_q, res_status_d;
  logic [CW-1:0]    res_comp_q, res_comp_d;
  logic             res_found_q, res_found_d;
  logic             res_same_q, res_same_d;

  logic             out_valid_q, out_valid_d;
  cct_pkg::status_e out_status_q, out_status_d;
  logic [CW-1:0]    out_comp_q, out_comp_d;
  logic             out_found_q, out_found_d;
  logic             out_same_q, out_same_d;

  // Component id memory: one write port, two registered read ports.
  logic [CW-1:0]    comp_mem [NUM];
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [CW-1:0]    mem_wdata;
  logic [IDX_W-1:0] rd0_addr, rd1_addr;
  logic [CW-1:0]    rd0_q, rd1_q;

  logic             in_stall;
  logic             a_ok, b_ok, va, vb;
  logic [IDX_W-1:0] a_idx, b_idx;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      comp_mem[mem_waddr] <= mem_wdata;
    end
    rd0_q <= comp_mem[rd0_addr];
    rd1_q <= comp_mem[rd1_addr];
  end

  assign a_ok  = 32'(a_q) < NUM;
  assign b_ok  = 32'(b_q) < NUM;
  assign a_idx = IDX_W'(a_q);
  assign b_idx = IDX_W'(b_q);
  assign va    = a_ok && valid_q[a_idx];
  assign vb    = b_ok && valid_q[b_idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cct_pkg::ST_IDLE;
      next_id_q   <= '0;
      valid_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      next_id_q   <= next_id_d;
      valid_q     <= valid_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    a_q          <= a_d;
    b_q          <= b_d;
    keep_q       <= keep_d;
    gone_q       <= gone_d;
    scan_q       <= scan_d;
    scan_addr_q  <= scan_addr_d;
    res_status_q <= res_status_d;
    res_comp_q   <= res_comp_d;
    res_found_q  <= res_found_d;
    res_same_q   <= res_same_d;
    out_status_q <= out_status_d;
    out_comp_q   <= out_comp_d;
    out_found_q  <= out_found_d;
    out_same_q   <= out_same_d;
  end

  always_comb begin
    state_d      = state_q;
    mode_d       = mode_q;
    a_d          = a_q;
    b_d          = b_q;
    next_id_d    = next_id_q;
    valid_d      = valid_q;
    keep_d       = keep_q;
    gone_d       = gone_q;
    scan_d       = scan_q;
    scan_addr_d  = scan_addr_q;
    pend_d       = pend_q;
    res_status_d = res_status_q;
    res_comp_d   = res_comp_q;
    res_found_d  = res_found_q;
    res_same_d   = res_same_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_comp_d   = out_comp_q;
    out_found_d  = out_found_q;
    out_same_d   = out_same_q;
    mem_we       = 1'b0;
    mem_waddr    = scan_addr_q;
    mem_wdata    = keep_q;
    rd0_addr     = IDX_W'(elem_a_i);
    rd1_addr     = IDX_W'(elem_b_i);
    in_stall     = 1'b1;

    unique case (state_q)
      cct_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid_i) begin
          mode_d  = cct_pkg::mode_e'(mode_i);
          a_d     = elem_a_i;
          b_d     = elem_b_i;
          state_d = cct_pkg::ST_LOOKUP;
        end
      end

      cct_pkg::ST_LOOKUP: begin
        res_status_d = cct_pkg::STATUS_OK;
        res_comp_d   = '0;
        res_found_d  = 1'b0;
        res_same_d   = 1'b0;
        state_d      = cct_pkg::ST_RESP;
        unique case (mode_q)
          cct_pkg::MODE_ADD: begin
            if (!a_ok) begin
              res_status_d = cct_pkg::STATUS_MISSING;
            end else if (valid_q[a_idx]) begin
              res_status_d = cct_pkg::STATUS_PRESENT;
            end else begin
              mem_we         = 1'b1;
              mem_waddr      = a_idx;
              mem_wdata      = next_id_q[CW-1:0];
              valid_d[a_idx] = 1'b1;
              res_comp_d     = next_id_q[CW-1:0];
              if (next_id_q != cct_pkg::ID_CNT_MAX) begin
                next_id_d = next_id_q + IDW'(1);
              end
            end
          end
          cct_pkg::MODE_CONNECT: begin
            if (!va || !vb) begin
              res_status_d = cct_pkg::STATUS_MISSING;
            end else if (rd0_q != rd1_q) begin
              keep_d  = rd0_q;
              gone_d  = rd1_q;
              scan_d  = '0;
              pend_d  = 1'b0;
              state_d = cct_pkg::ST_SCAN;
            end
          end
          cct_pkg::MODE_QUERY: begin
            res_found_d = va;
            res_comp_d  = va ? rd0_q : '0;
          end
          cct_pkg::MODE_SAME: begin
            res_same_d = va && vb && (rd0_q == rd1_q);
          end
        endcase
      end

      cct_pkg::ST_SCAN: begin
        // Read slot scan_q now; its data returns next cycle tagged by scan_addr_q.
        rd0_addr = scan_q[IDX_W-1:0];
        if (pend_q && valid_q[scan_addr_q] && (rd0_q == gone_q)) begin
          mem_we    = 1'b1;
          mem_waddr = scan_addr_q;
          mem_wdata = keep_q;
        end
        if (scan_q != CNT_W'(NUM)) begin
          scan_d      = scan_q + CNT_W'(1);
          scan_addr_d = scan_q[IDX_W-1:0];
          pend_d      = 1'b1;
        end else begin
          pend_d  = 1'b0;
          state_d = cct_pkg::ST_RESP;
        end
      end

      cct_pkg::ST_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_comp_d   = res_comp_q;
          out_found_d  = res_found_q;
          out_same_d   = res_same_q;
          state_d      = cct_pkg::ST_IDLE;
        end
      end
    endcase
  end

  assign in_stall_o  = in_stall;
  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign comp_id_o   = out_comp_q;
  assign found_o     = out_found_q;
  assign same_o      = out_same_q;

endmodule

/* hdl/cct_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cct_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_i,
  input logic                       out_valid_i,
  input logic                       out_stall_i,
  input logic [1:0]                 status_i,
  input logic [cct_pkg::COMP_W-1:0] comp_id_i,
  input logic                       found_i,
  input logic                       same_i
);

  logic [cct_pkg::COMP_W+3:0] out_word;
  logic                       flags_set;

  assign out_word  = {status_i, comp_id_i, found_i, same_i};
  assign flags_set = found_i || same_i;

  // The block handles one operation at a time, so it is busy right after taking a word.
  `CCT_ASSERT(busy_after_accept, in_valid_i && !in_stall_i |=> in_stall_i)

  `CCT_ASSERT(out_held_on_stall, out_valid_i && out_stall_i |=> out_valid_i && $stable(out_word))

  `CCT_ASSERT(status_legal, out_valid_i |-> status_i <= cct_pkg::STATUS_MISSING)

  // Found and same come only from lookups, which never report an error.
  `CCT_ASSERT(flags_only_ok, out_valid_i && flags_set |-> status_i == cct_pkg::STATUS_OK)

  `CCT_ASSERT(flags_exclusive, out_valid_i |-> !(found_i && same_i))

endmodule

bind connected_component_tracker cct_checker u_cct_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .status_i    (status_o),
  .comp_id_i   (comp_id_o),
  .found_i     (found_o),
  .same_i      (same_o)
);

/* dv/connected_component_checker.sv */
`timescale 1ns / 1ps

module connected_component_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic [1:0]                 mode_i,
  input  logic [cct_pkg::ELEM_W-1:0] elem_a_i,
  input  logic [cct_pkg::ELEM_W-1:0] elem_b_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic [1:0]                 status_i,
  input  logic [cct_pkg::COMP_W-1:0] comp_id_i,
  input  logic                       found_i,
  input  logic                       same_i,
  output int                         fail_count_o,
  output int                         pending_o
);

  typedef struct {
    cct_pkg::status_e           status;
    logic [cct_pkg::COMP_W-1:0] comp_id;
    logic                       found;
    logic                       same;
  } answer_t;

  logic                         occupied [cct_pkg::NUM_ELEMENTS];
  logic [cct_pkg::COMP_W-1:0]   label    [cct_pkg::NUM_ELEMENTS];
  logic [cct_pkg::ID_CNT_W-1:0] next_id;
  answer_t                      pending_answers [$];
  answer_t                      want;
  int                           mismatches = 0;
  int                           waiting    = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = waiting;

  task automatic report(input string what);
    mismatches++;
    $display("%0t ns: result mismatch: %s", $time, what);
  endtask

  function automatic bit is_live(int idx);
    return idx < cct_pkg::NUM_ELEMENTS && occupied[idx];
  endfunction

  // Applies one operation to the shadow table and returns the word it should produce.
  function automatic answer_t resolve_op(cct_pkg::mode_e op,
                                         logic [cct_pkg::ELEM_W-1:0] a,
                                         logic [cct_pkg::ELEM_W-1:0] b);
    answer_t                    ans;
    logic [cct_pkg::COMP_W-1:0] keep;
    logic [cct_pkg::COMP_W-1:0] gone;
    ans.status  = cct_pkg::STATUS_OK;
    ans.comp_id = '0;
    ans.found   = 1'b0;
    ans.same    = 1'b0;
    case (op)
      cct_pkg::MODE_ADD: begin
        if (a >= cct_pkg::NUM_ELEMENTS) begin
          ans.status = cct_pkg::STATUS_MISSING;
        end else if (occupied[a]) begin
          ans.status = cct_pkg::STATUS_PRESENT;
        end else begin
          occupied[a] = 1'b1;
          label[a]    = next_id[cct_pkg::COMP_W-1:0];
          ans.comp_id = next_id[cct_pkg::COMP_W-1:0];
          if (next_id != cct_pkg::ID_CNT_MAX) next_id++;
        end
      end
      cct_pkg::MODE_CONNECT: begin
        if (!is_live(a) || !is_live(b)) begin
          ans.status = cct_pkg::STATUS_MISSING;
        end else begin
          keep = label[a];
          gone = label[b];
          if (keep != gone) begin
            for (int i = 0; i < cct_pkg::NUM_ELEMENTS; i++) begin
              if (occupied[i] && label[i] == gone) label[i] = keep;
            end
          end
        end
      end
      cct_pkg::MODE_QUERY: begin
        if (is_live(a)) begin
          ans.found   = 1'b1;
          ans.comp_id = label[a];
        end
      end
      default: begin
        if (is_live(a) && is_live(b) && label[a] == label[b]) ans.same = 1'b1;
      end
    endcase
    return ans;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < cct_pkg::NUM_ELEMENTS; i++) begin
        occupied[i] = 1'b0;
        label[i]    = '0;
      end
      next_id = '0;
      pending_answers.delete();
      waiting <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (pending_answers.size() == 0) begin
          report("result word with no operation outstanding");
        end else begin
          want = pending_answers.pop_front();
          if (status_i !== want.status)
            report($sformatf("status %0d, expected %0d", status_i, want.status));
          if (comp_id_i !== want.comp_id)
            report($sformatf("comp_id %0d, expected %0d", comp_id_i, want.comp_id));
          if (found_i !== want.found)
            report($sformatf("found %0b, expected %0b", found_i, want.found));
          if (same_i !== want.same)
            report($sformatf("same %0b, expected %0b", same_i, want.same));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        pending_answers.push_back(resolve_op(cct_pkg::mode_e'(mode_i), elem_a_i, elem_b_i));
      end
      waiting <= pending_answers.size();
    end
  end

endmodule

/* dv/tb_connected_component_tracker.sv */
`timescale 1ns / 1ps

module tb_connected_component_tracker;

  localparam int unsigned EW = cct_pkg::ELEM_W;
  localparam int unsigned CW = cct_pkg::COMP_W;

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          in_valid_i  = 1'b0;
  logic          in_stall_o;
  logic [1:0]    mode_i      = '0;
  logic [EW-1:0] elem_a_i    = '0;
  logic [EW-1:0] elem_b_i    = '0;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  logic [1:0]    status_o;
  logic [CW-1:0] comp_id_o;
  logic          found_o;
  logic          same_o;

  int            fail_count;
  int            results_owed;
  int            ops_sent   = 0;
  int            burst_left = 0;
  bit            known [cct_pkg::NUM_ELEMENTS];
  logic [EW-1:0] known_q [$];

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  connected_component_tracker dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .elem_a_i    (elem_a_i),
    .elem_b_i    (elem_b_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .comp_id_o   (comp_id_o),
    .found_o     (found_o),
    .same_o      (same_o)
  );

  connected_component_checker results_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .mode_i       (mode_i),
    .elem_a_i     (elem_a_i),
    .elem_b_i     (elem_b_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_i     (status_o),
    .comp_id_i    (comp_id_o),
    .found_i      (found_o),
    .same_i       (same_o),
    .fail_count_o (fail_count),
    .pending_o    (results_owed)
  );

  // Offers one word, waits until it is taken, then maybe pauses between bursts.
  task automatic send_op(input cct_pkg::mode_e op, input logic [EW-1:0] a,
                         input logic [EW-1:0] b);
    int gap;
    in_valid_i <= 1'b1;
    mode_i     <= op;
    elem_a_i   <= a;
    elem_b_i   <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    ops_sent++;
    if (op == cct_pkg::MODE_ADD && !known[a]) begin
      known[a] = 1'b1;
      known_q.push_back(a);
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Mostly elements already added, so connects and lookups reach the table.
  function automatic logic [EW-1:0] pick_elem();
    if (known_q.size() != 0 && $urandom_range(0, 9) < 8)
      return known_q[$urandom_range(0, known_q.size() - 1)];
    return EW'($urandom);
  endfunction

  initial begin
    int            pick;
    logic [EW-1:0] a;
    logic [EW-1:0] b;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_op(cct_pkg::MODE_ADD,     8'd0,   8'd255);
    send_op(cct_pkg::MODE_ADD,     8'd255, 8'd0);
    send_op(cct_pkg::MODE_ADD,     8'd0,   8'd0);
    send_op(cct_pkg::MODE_QUERY,   8'd0,   8'd255);
    send_op(cct_pkg::MODE_QUERY,   8'd255, 8'd0);
    send_op(cct_pkg::MODE_QUERY,   8'hAA,  8'h55);
    send_op(cct_pkg::MODE_SAME,    8'd0,   8'd255);
    send_op(cct_pkg::MODE_SAME,    8'd0,   8'h55);
    send_op(cct_pkg::MODE_CONNECT, 8'd0,   8'h55);
    send_op(cct_pkg::MODE_CONNECT, 8'h55,  8'd255);
    send_op(cct_pkg::MODE_CONNECT, 8'h55,  8'hAA);
    send_op(cct_pkg::MODE_ADD,     8'h55,  8'hAA);
    send_op(cct_pkg::MODE_CONNECT, 8'd0,   8'd255);
    send_op(cct_pkg::MODE_QUERY,   8'd255, 8'hFF);
    send_op(cct_pkg::MODE_SAME,    8'd255, 8'd0);
    send_op(cct_pkg::MODE_CONNECT, 8'd255, 8'd0);
    send_op(cct_pkg::MODE_ADD,     8'hAA,  8'h55);
    send_op(cct_pkg::MODE_CONNECT, 8'hAA,  8'h55);
    send_op(cct_pkg::MODE_CONNECT, 8'h55,  8'd0);
    send_op(cct_pkg::MODE_SAME,    8'd255, 8'hAA);
    send_op(cct_pkg::MODE_QUERY,   8'd0,   8'd0);
    send_op(cct_pkg::MODE_SAME,    8'd7,   8'd7);
    send_op(cct_pkg::MODE_CONNECT, 8'd0,   8'd0);
    send_op(cct_pkg::MODE_SAME,    8'hAA,  8'hAA);

    repeat (1600) begin
      pick = $urandom_range(0, 99);
      a    = pick_elem();
      b    = pick_elem();
      if (pick < 20)      send_op(cct_pkg::MODE_ADD, EW'($urandom), b);
      else if (pick < 50) send_op(cct_pkg::MODE_CONNECT, a, b);
      else if (pick < 75) send_op(cct_pkg::MODE_QUERY, a, b);
      else                send_op(cct_pkg::MODE_SAME, a, b);
    end
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (results_owed != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_connected_component_tracker: clean");
    end else begin
      $display("tb_connected_component_tracker: errors");
    end
    $finish;
  end

  // Receiver: stretches of free flow, random stalls and solid stalls, plus one
  // long hold early on so the block backs up into its input.
  initial begin
    int style;
    int span;
    bit held_off;
    held_off = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!held_off && ops_sent >= 60) begin
        held_off = 1'b1;
        repeat (600) begin
          @(posedge clk_i);
          out_stall_i <= 1'b1;
        end
      end
      style = $urandom_range(0, 9);
      span  = $urandom_range(1, 40);
      repeat (span) begin
        @(posedge clk_i);
        if (style < 4)       out_stall_i <= 1'b0;
        else if (style < 8)  out_stall_i <= 1'($urandom_range(0, 1));
        else if (style == 8) out_stall_i <= ($urandom_range(0, 4) != 0);
        else                 out_stall_i <= 1'b1;
      end
    end
  end

  initial begin
    #40_000_000;
    $display("tb_connected_component_tracker: errors");
    $finish;
  end

endmodule
